// ===== rtl/core/mpl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the log2 interpolation table for the min-p logit filter.
// Standalone package; used by every module of the block.
package mpl_pkg;

  localparam int LogitWidth      = 24;
  localparam int FracWidth       = 17;
  localparam int LogTableEntries = 16;
  localparam int TabIdxW         = $clog2(LogTableEntries + 1);
  localparam int QueueDepth      = 4;
  localparam int QPtrW           = $clog2(QueueDepth);
  localparam int QCntW           = $clog2(QueueDepth + 1);
  localparam int MagWidth        = 17;
  localparam int DistWidth       = 21;
  localparam int ThrW            = ((LogitWidth > MagWidth) ? LogitWidth : MagWidth) + 1;

  localparam logic [FracWidth-1:0]         FracOne = FracWidth'(65536);
  localparam logic [15:0]                  Ln2Q16  = 16'd45426;
  localparam logic signed [LogitWidth-1:0] NegInf  = {1'b1, {(LogitWidth - 1){1'b0}}};

  localparam logic CmdMax  = 1'b0;
  localparam logic CmdMask = 1'b1;

  typedef enum logic {
    BkRun,
    BkLog
  } back_state_e;

  typedef struct packed {
    logic                         cmd;
    logic signed [LogitWidth-1:0] logit;
    logic [FracWidth-1:0]         frac;
    logic                         first;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic                 start;
    logic [FracWidth-1:0] frac;
  } ln_req_t;

  typedef struct packed {
    logic                done;
    logic [MagWidth-1:0] mag;
  } ln_rsp_t;

  typedef logic [16:0] log_tab_t [LogTableEntries + 1];

  function automatic log_tab_t build_log_table();
    log_tab_t    tab;
    logic [63:0] v;
    logic [16:0] r;
    for (int i = 0; i <= LogTableEntries; i++) begin
      if (i == LogTableEntries) begin
        tab[i] = 17'h10000;
      end else begin
        v = ((64'(LogTableEntries) + 64'(i)) << 30) / LogTableEntries;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
          v = (v * v) >> 30;
          if (v >= (64'd2 << 30)) begin
            r[b] = 1'b1;
            v    = v >> 1;
          end
        end
        tab[i] = r;
      end
    end
    return tab;
  endfunction

  localparam log_tab_t LogTable = build_log_table();

endpackage

// ===== rtl/core/min_p_logit_filter_unit.sv =====
`timescale 1ns / 1ps
// Min-p logit filter top level: front end, beat queue and back end. Depends on mpl_pkg.
// Throughput: one beat per cycle on either pass, mask-pass beats only while the output is not
// stalled; a row's last max-pass beat holds the back end while the logarithm pipeline runs.
// A mask-pass beat passes through the queue and then the output register.
// Reset: asynchronous, clears queue, row state (maximum and threshold to minus infinity,
// fraction to zero) and the output valid flag.
module min_p_logit_filter_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  cmd_i,
  input  logic signed [mpl_pkg::LogitWidth-1:0] logit_in_i,
  input  logic [mpl_pkg::FracWidth-1:0]         min_p_i,
  input  logic                                  last_in_row_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mpl_pkg::LogitWidth-1:0] logit_out_o,
  output logic                                  was_masked_o,
  output logic                                  last_out_o
);

  mpl_pkg::item_t push_item, pop_item;
  logic           push, pop, q_full, q_valid;

  mpl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .logit_in_i   (logit_in_i),
    .min_p_i      (min_p_i),
    .last_in_row_i(last_in_row_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  mpl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_item_o (pop_item)
  );

  mpl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .logit_out_o (logit_out_o),
    .was_masked_o(was_masked_o),
    .last_out_o  (last_out_o)
  );

endmodule

// ===== rtl/core/mpl_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, saturates min_p and tags the first max-pass beat of a row.
// Depends on mpl_pkg.
module mpl_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 cmd_i,
  input  logic signed [mpl_pkg::LogitWidth-1:0] logit_in_i,
  input  logic [mpl_pkg::FracWidth-1:0]        min_p_i,
  input  logic                                 last_in_row_i,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output mpl_pkg::item_t                       item_o
);

  logic row_start_q, row_start_d;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    item_o.cmd   = cmd_i;
    item_o.logit = logit_in_i;
    item_o.frac  = (min_p_i > mpl_pkg::FracOne) ? mpl_pkg::FracOne : min_p_i;
    item_o.first = row_start_q && (cmd_i == mpl_pkg::CmdMax);
    item_o.last  = last_in_row_i;
  end

  always_comb begin
    row_start_d = row_start_q;
    if (push_o && (cmd_i == mpl_pkg::CmdMax)) begin
      row_start_d = last_in_row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_start_q <= 1'b1;
    end else begin
      row_start_q <= row_start_d;
    end
  end

endmodule

// ===== rtl/core/mpl_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO between front and back end, holding classified beats.
// Depends on mpl_pkg.
module mpl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpl_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mpl_pkg::item_t pop_item_o
);

  mpl_pkg::item_t                 mem_q [mpl_pkg::QueueDepth];
  logic [mpl_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mpl_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mpl_pkg::QCntW-1:0]      count_q, count_d;

  assign full_o     = (count_q == mpl_pkg::QCntW'(mpl_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mpl_pkg::QPtrW'(mpl_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mpl_pkg::QPtrW'(mpl_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/core/mpl_ln_unit.sv =====
`timescale 1ns / 1ps
// Three-stage pipeline giving |ln(f / 2^16)| in Q.12 for a Q0.16 fraction f.
// Depends on mpl_pkg (log2 table, ln 2 scale).
module mpl_ln_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpl_pkg::ln_req_t req_i,
  output mpl_pkg::ln_rsp_t rsp_o
);

  logic [2:0]                        vld_q;
  logic [4:0]                        lead;
  logic [4:0]                        shift;
  logic [32:0]                       shifted;
  logic [15:0]                       mant;
  logic [16+mpl_pkg::TabIdxW-1:0]    mn;
  logic [mpl_pkg::TabIdxW-1:0]       idx;
  logic [16:0]                       lo, hi;

  logic [16:0]                       lo_q, diff_q;
  logic [15:0]                       rem_q;
  logic [4:0]                        shift_q;

  logic [32:0]                       prod;
  logic [17:0]                       frac;
  logic [mpl_pkg::DistWidth-1:0]     dist_d, dist_q;

  logic [36:0]                       scaled;
  logic [mpl_pkg::MagWidth-1:0]      mag_q;

  always_comb begin
    lead = '0;
    for (int b = 0; b < mpl_pkg::FracWidth; b++) begin
      if (req_i.frac[b]) begin
        lead = 5'(b);
      end
    end
    shift   = 5'(16) - lead;
    shifted = 33'(req_i.frac) << shift;
    mant    = shifted[15:0];
    mn      = (16 + mpl_pkg::TabIdxW)'(mant) *
              (16 + mpl_pkg::TabIdxW)'(mpl_pkg::LogTableEntries);
    idx     = mn[16 +: mpl_pkg::TabIdxW];
    lo      = mpl_pkg::LogTable[idx];
    hi      = mpl_pkg::LogTable[idx + 1'b1];
  end

  always_comb begin
    prod   = 33'(diff_q) * 33'(rem_q);
    frac   = 18'(lo_q) + 18'(prod[32:16]);
    dist_d = (mpl_pkg::DistWidth'(shift_q) << 16) - mpl_pkg::DistWidth'(frac);
    scaled = 37'(dist_q) * 37'(mpl_pkg::Ln2Q16) + 37'(1 << 19);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], req_i.start};
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo;
    diff_q  <= hi - lo;
    rem_q   <= mn[15:0];
    shift_q <= shift;
    dist_q  <= dist_d;
    mag_q   <= scaled[36:20];
  end

  assign rsp_o.done = vld_q[2];
  assign rsp_o.mag  = mag_q;

endmodule

// ===== rtl/core/mpl_back.sv =====
`timescale 1ns / 1ps
// Back end: tracks the row maximum, sets the threshold and masks mask-pass beats.
// Depends on mpl_pkg and mpl_ln_unit.
module mpl_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_valid_i,
  input  mpl_pkg::item_t                        q_item_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mpl_pkg::LogitWidth-1:0] logit_out_o,
  output logic                                  was_masked_o,
  output logic                                  last_out_o
);

  mpl_pkg::back_state_e                  state_q, state_d;
  mpl_pkg::ln_req_t                      ln_req;
  mpl_pkg::ln_rsp_t                      ln_rsp;

  logic signed [mpl_pkg::LogitWidth-1:0] max_q, max_d;
  logic signed [mpl_pkg::LogitWidth-1:0] thr_q, thr_d;
  logic [mpl_pkg::FracWidth-1:0]         frac_q, frac_d;
  logic signed [mpl_pkg::ThrW-1:0]       thr_full;
  logic                                  masked;
  logic                                  pop_max, pop_mask;

  logic                                  out_valid_q;
  logic signed [mpl_pkg::LogitWidth-1:0] out_logit_q;
  logic                                  out_masked_q, out_last_q;

  mpl_ln_unit u_ln (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ln_req),
    .rsp_o (ln_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      mpl_pkg::BkRun: begin
        if (pop_max && q_item_i.last) begin
          state_d = mpl_pkg::BkLog;
        end
      end
      mpl_pkg::BkLog: begin
        if (ln_rsp.done) begin
          state_d = mpl_pkg::BkRun;
        end
      end
      default: state_d = mpl_pkg::BkRun;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    case (state_q)
      mpl_pkg::BkRun: begin
        pop_o = q_valid_i && ((q_item_i.cmd == mpl_pkg::CmdMax) || !out_valid_q || out_ready_i);
      end
      mpl_pkg::BkLog: pop_o = 1'b0;
      default:        pop_o = 1'b0;
    endcase
  end

  assign pop_max  = pop_o && (q_item_i.cmd == mpl_pkg::CmdMax);
  assign pop_mask = pop_o && (q_item_i.cmd == mpl_pkg::CmdMask);
  assign masked   = (frac_q != '0) && ($signed(q_item_i.logit) < thr_q);

  always_comb begin
    max_d  = max_q;
    frac_d = frac_q;
    if (pop_max) begin
      if (q_item_i.first) begin
        max_d  = q_item_i.logit;
        frac_d = q_item_i.frac;
      end else if ($signed(q_item_i.logit) > max_q) begin
        max_d = q_item_i.logit;
      end
    end
    ln_req.start = pop_max && q_item_i.last;
    ln_req.frac  = frac_d;
  end

  always_comb begin
    thr_full = mpl_pkg::ThrW'(max_q) - $signed(mpl_pkg::ThrW'(ln_rsp.mag));
    thr_d    = thr_q;
    if (ln_rsp.done) begin
      if ((frac_q == '0) || (thr_full < mpl_pkg::ThrW'(mpl_pkg::NegInf))) begin
        thr_d = mpl_pkg::NegInf;
      end else begin
        thr_d = mpl_pkg::LogitWidth'(thr_full);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpl_pkg::BkRun;
      max_q       <= mpl_pkg::NegInf;
      thr_q       <= mpl_pkg::NegInf;
      frac_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      max_q   <= max_d;
      thr_q   <= thr_d;
      frac_q  <= frac_d;
      if (pop_mask) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_mask) begin
      out_logit_q  <= masked ? mpl_pkg::NegInf : q_item_i.logit;
      out_masked_q <= masked;
      out_last_q   <= q_item_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign logit_out_o  = out_logit_q;
  assign was_masked_o = out_masked_q;
  assign last_out_o   = out_last_q;

`ifndef ASSERT_OFF
  a_no_pop_in_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mpl_pkg::BkLog) |-> !pop_o)
    else $error("beat popped while threshold pending");

  a_done_in_log: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_rsp.done |-> (state_q == mpl_pkg::BkLog))
    else $error("log result outside threshold wait");

  a_masked_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_masked_q) |-> (out_logit_q == mpl_pkg::NegInf))
    else $error("masked beat not minus infinity");
`endif

endmodule
